### hdl/ofrp_pkg.sv
// ----------------------------------------------------------------------------
// ofrp_pkg: shared types and constants of the oldest-first request panel
// Holds the line count, the transaction payload structs and the action codes.
// ----------------------------------------------------------------------------
package ofrp_pkg;

  localparam int NUM_LINES = 16;
  localparam int LINE_W    = 4;
  localparam int CFG_W     = 5;

  typedef logic [NUM_LINES-1:0]                 line_mask_t;
  typedef logic [NUM_LINES-1:0][NUM_LINES-1:0] age_matrix_t;

  typedef enum logic [1:0] {
    ACT_PRESS = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_SPARE = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [LINE_W-1:0] line;
  } in_item_t;

  typedef struct packed {
    logic              oldest_valid;
    logic [LINE_W-1:0] oldest_line;
    logic              line_pending;
  } out_item_t;

endpackage

### hdl/ofrp_oldest_sel.sv
// ----------------------------------------------------------------------------
// ofrp_oldest_sel: oldest pending line search
// Finds the pending line that no other pending line is older than.
// ----------------------------------------------------------------------------
module ofrp_oldest_sel (
  input  ofrp_pkg::line_mask_t          pending,
  input  ofrp_pkg::age_matrix_t         older,
  output logic                          oldest_valid,
  output logic [ofrp_pkg::LINE_W-1:0]   oldest_line
);

  ofrp_pkg::line_mask_t has_older;
  ofrp_pkg::line_mask_t cand;

  always_comb begin
    has_older = '0;
    for (int i = 0; i < ofrp_pkg::NUM_LINES; i++) begin
      for (int j = 0; j < ofrp_pkg::NUM_LINES; j++) begin
        if (j != i && pending[j] && older[j][i]) begin
          has_older[i] = 1'b1;
        end
      end
    end
    cand = pending & ~has_older;
  end

  always_comb begin
    oldest_valid = |cand;
    oldest_line  = '0;
    for (int i = ofrp_pkg::NUM_LINES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        oldest_line = ofrp_pkg::LINE_W'(i);
      end
    end
  end

endmodule

### hdl/ofrp_panel_state.sv
// ----------------------------------------------------------------------------
// ofrp_panel_state: pending flags, age matrix and line count register
// Computes the state after one transaction and the result it produces.
// ----------------------------------------------------------------------------
module ofrp_panel_state (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ofrp_pkg::CFG_W-1:0]    cfg_wr_data,
  input  ofrp_pkg::in_item_t            item,
  input  logic                          commit,
  output ofrp_pkg::out_item_t           result
);

  logic [ofrp_pkg::CFG_W-1:0] lines_r;
  ofrp_pkg::line_mask_t       pending_r;
  ofrp_pkg::line_mask_t       pending_nxt;
  ofrp_pkg::age_matrix_t      older_r;
  ofrp_pkg::age_matrix_t      older_nxt;
  logic [ofrp_pkg::CFG_W-1:0] eff_lines;
  logic [ofrp_pkg::CFG_W-1:0] cfg_eff;
  ofrp_pkg::line_mask_t       cfg_mask;
  ofrp_pkg::line_mask_t       line_bit;
  logic                       present;
  logic                       press_new;
  logic                       sel_valid;
  logic [ofrp_pkg::LINE_W-1:0] sel_line;

  function automatic logic [ofrp_pkg::CFG_W-1:0] saturate(
    input logic [ofrp_pkg::CFG_W-1:0] cnt
  );
    logic [ofrp_pkg::CFG_W-1:0] lim;
    lim = ofrp_pkg::CFG_W'(ofrp_pkg::NUM_LINES);
    return (cnt > lim) ? lim : cnt;
  endfunction

  always_comb begin
    eff_lines = saturate(lines_r);
    cfg_eff   = saturate(cfg_wr_data);
    for (int i = 0; i < ofrp_pkg::NUM_LINES; i++) begin
      cfg_mask[i] = ofrp_pkg::CFG_W'(i) < cfg_eff;
    end
  end

  always_comb begin
    present   = ofrp_pkg::CFG_W'(item.line) < eff_lines;
    line_bit  = ofrp_pkg::line_mask_t'(1) << item.line;
    press_new = present && (item.action == ofrp_pkg::ACT_PRESS) && !pending_r[item.line];
    pending_nxt = pending_r;
    older_nxt   = older_r;
    if (press_new) begin
      pending_nxt = pending_r | line_bit;
      for (int i = 0; i < ofrp_pkg::NUM_LINES; i++) begin
        if (pending_r[i]) begin
          older_nxt[i] = older_r[i] | line_bit;
        end
      end
      older_nxt[item.line] = '0;
    end else if (present && (item.action == ofrp_pkg::ACT_CLEAR)) begin
      pending_nxt = pending_r & ~line_bit;
    end
  end

  ofrp_oldest_sel u_oldest_sel (
    .pending      (pending_nxt),
    .older        (older_nxt),
    .oldest_valid (sel_valid),
    .oldest_line  (sel_line)
  );

  always_comb begin
    result.oldest_valid = sel_valid;
    result.oldest_line  = sel_line;
    result.line_pending = present & pending_nxt[item.line];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lines_r   <= ofrp_pkg::CFG_W'(ofrp_pkg::NUM_LINES);
      pending_r <= '0;
    end else if (cfg_wr_en) begin
      lines_r   <= cfg_wr_data;
      pending_r <= pending_r & cfg_mask;
    end else if (commit) begin
      pending_r <= pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r <= '0;
    end else if (commit) begin
      older_r <= older_nxt;
    end
  end

endmodule

### hdl/oldest_first_request_panel_top.sv
// ----------------------------------------------------------------------------
// oldest_first_request_panel_top: request panel with oldest-first selection
// Keeps a pending flag per request line and reports the oldest pending line.
// ----------------------------------------------------------------------------
// The panel accepts one transaction every cycle while its result is not
// stalled. Each transaction is captured in an input register,
// then a single pass updates the pending flags and the age matrix and searches
// the updated matrix for the oldest pending line, and the result register
// holds the answer until it is taken. A stalled result stalls the input
// register, so the input side keeps taking transactions as long as one stage
// is free.
module oldest_first_request_panel_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ofrp_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ofrp_pkg::out_item_t        out_data,
  input  logic                       cfg_wr_en,
  input  logic [ofrp_pkg::CFG_W-1:0] cfg_wr_data
);

  ofrp_pkg::in_item_t  item_r;
  logic                item_valid_r;
  ofrp_pkg::out_item_t result;
  ofrp_pkg::out_item_t out_data_r;
  logic                out_valid_r;
  logic                fire;

  assign fire     = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !item_valid_r || fire;

  ofrp_panel_state u_panel_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item_r),
    .commit      (fire),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        item_valid_r <= in_valid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_data;
    end
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
